### hdl/dpp_pkg.sv
`default_nettype none

package dpp_pkg;

  localparam int unsigned DIV_BITS  = 64;
  localparam int unsigned CORE_ST   = 19;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_K1        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_K2        = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P1        = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P2        = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_K3        = 4'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEPTH = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

  typedef logic signed [63:0] q64_t;

  // divider work item: w holds dividend bits, then shifts in quotient bits
  typedef struct packed {
    logic        zbad;
    logic        negx;
    logic        negy;
    logic [30:0] d;
    logic [63:0] wx;
    logic [63:0] wy;
    logic [30:0] rx;
    logic [30:0] ry;
  } div_t;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] k3;
  } cfg_t;

  typedef struct packed {
    logic zbad;
    logic sat;
    q64_t u;
    q64_t v;
  } core_out_t;

endpackage

`default_nettype wire

### hdl/dpp_front.sv
`default_nettype none

module dpp_front import dpp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] point_z_i,
  input  wire logic        pop_i,
  output logic             valid_o,
  output div_t             data_o
);

  div_t        mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push, pop;
  div_t        entry;
  logic [31:0] magx, magy;

  always_comb begin
    entry      = '0;
    entry.zbad = point_z_i[31] | (point_z_i == 32'd0);
    entry.d    = entry.zbad ? 31'd1 : point_z_i[30:0];
    entry.negx = point_x_i[31];
    entry.negy = point_y_i[31];
    magx       = point_x_i[31] ? (~point_x_i + 32'd1) : point_x_i;
    magy       = point_y_i[31] ? (~point_y_i + 32'd1) : point_y_i;
    entry.wx   = {magx, 32'd0} + 64'(entry.d[30:1]);
    entry.wy   = {magy, 32'd0} + 64'(entry.d[30:1]);
  end

  assign in_stall_o = count_q[1];
  assign push       = in_valid_i & ~count_q[1];
  assign valid_o    = count_q != 2'd0;
  assign pop        = pop_i & valid_o;
  assign data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

### hdl/dpp_div.sv
`default_nettype none

module dpp_div import dpp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic valid_i,
  input  div_t      data_i,
  output logic      valid_o,
  output div_t      data_o
);

  div_t                stage_q [DIV_BITS];
  logic [DIV_BITS-1:0] vld_q;

  // one restoring step for x and y
  function automatic div_t div_step(div_t s);
    div_t        r;
    logic [31:0] tx, ty;
    logic        gx, gy;
    r  = s;
    tx = {s.rx, s.wx[63]};
    ty = {s.ry, s.wy[63]};
    gx = tx >= {1'b0, s.d};
    gy = ty >= {1'b0, s.d};
    r.rx = gx ? 31'(tx - {1'b0, s.d}) : tx[30:0];
    r.ry = gy ? 31'(ty - {1'b0, s.d}) : ty[30:0];
    r.wx = {s.wx[62:0], gx};
    r.wy = {s.wy[62:0], gy};
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q[0] <= div_step(data_i);
      for (int i = 1; i < DIV_BITS; i++) begin
        stage_q[i] <= div_step(stage_q[i-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[DIV_BITS-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[DIV_BITS-1];
  assign data_o  = stage_q[DIV_BITS-1];

endmodule

`default_nettype wire

### hdl/dpp_core.sv
`default_nettype none

module dpp_core import dpp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  cfg_t      cfg_i,
  input  wire logic valid_i,
  input  div_t      data_i,
  output logic      valid_o,
  output core_out_t data_o
);

  localparam q64_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q64_t Q_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic        neg;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  typedef struct packed {
    logic flag;
    q64_t val;
  } res_t;

  typedef struct packed {
    logic          zbad;
    logic          sat;
    logic          ssq;
    logic          s4;
    logic          s6;
    logic          st;
    q64_t          xn, yn, x2, y2, xy, r2, txy, x2d, y2d, tx, ty;
    q64_t          r4, r6, k1r2, k2r4, k3r6, rad;
    q64_t          p1txy, p2tx, p2txy, p1ty, xd, yd;
    pp_t [3:0]     pp;
  } core_t;

  function automatic res_t from_mag(logic neg, logic [63:0] m);
    res_t r;
    r.flag = 1'b0;
    if (neg) begin
      if (m > 64'h8000_0000_0000_0000) begin
        r.flag = 1'b1;
        r.val  = Q_MIN;
      end else begin
        r.val = q64_t'(64'd0 - m);
      end
    end else if (m[63]) begin
      r.flag = 1'b1;
      r.val  = Q_MAX;
    end else begin
      r.val = q64_t'(m);
    end
    return r;
  endfunction

  function automatic pp_t mul_pp(q64_t a, q64_t b);
    pp_t         p;
    logic [63:0] ua, ub;
    ua    = a[63] ? (~a + 64'd1) : a;
    ub    = b[63] ? (~b + 64'd1) : b;
    p.neg = a[63] ^ b[63];
    p.p00 = 64'(ua[31:0]) * 64'(ub[31:0]);
    p.p01 = 64'(ua[31:0]) * 64'(ub[63:32]);
    p.p10 = 64'(ua[63:32]) * 64'(ub[31:0]);
    p.p11 = 64'(ua[63:32]) * 64'(ub[63:32]);
    return p;
  endfunction

  function automatic res_t mul_fin(pp_t p);
    res_t        r;
    logic [65:0] mid;
    logic [63:0] lo, hi;
    logic [64:0] lo2;
    mid = 66'(p.p00[63:32]) + 66'(p.p01[31:0]) + 66'(p.p10[31:0]);
    lo  = {mid[31:0], p.p00[31:0]};
    lo2 = 65'(lo) + 65'h0_8000_0000;
    hi  = p.p11 + 64'(p.p01[63:32]) + 64'(p.p10[63:32]) + 64'(mid[65:32])
        + 64'(lo2[64]);
    if (hi[63:32] != 32'd0) begin
      r.flag = 1'b1;
      r.val  = p.neg ? Q_MIN : Q_MAX;
    end else begin
      r = from_mag(p.neg, {hi[31:0], lo2[63:32]});
    end
    return r;
  endfunction

  function automatic res_t add_sat(q64_t a, q64_t b);
    res_t r;
    q64_t s;
    s      = a + b;
    r.flag = (a[63] == b[63]) && (s[63] != a[63]);
    r.val  = r.flag ? (a[63] ? Q_MIN : Q_MAX) : s;
    return r;
  endfunction

  q64_t k1, k2, k3, p1, p2, fxq, fyq, cxq, cyq;
  logic use_k1, use_k2, use_k3, use_p;

  assign k1  = {{28{cfg_i.k1[31]}}, cfg_i.k1, 4'd0};
  assign k2  = {{28{cfg_i.k2[31]}}, cfg_i.k2, 4'd0};
  assign k3  = {{28{cfg_i.k3[31]}}, cfg_i.k3, 4'd0};
  assign p1  = {{28{cfg_i.p1[31]}}, cfg_i.p1, 4'd0};
  assign p2  = {{28{cfg_i.p2[31]}}, cfg_i.p2, 4'd0};
  assign fxq = {16'd0, cfg_i.fx, 16'd0};
  assign fyq = {16'd0, cfg_i.fy, 16'd0};
  assign cxq = {16'd0, cfg_i.cx, 16'd0};
  assign cyq = {16'd0, cfg_i.cy, 16'd0};
  assign use_k1 = cfg_i.k1 != 32'd0;
  assign use_k2 = cfg_i.k2 != 32'd0;
  assign use_k3 = cfg_i.k3 != 32'd0;
  assign use_p  = (cfg_i.p1 != 32'd0) || (cfg_i.p2 != 32'd0);

  core_t              st_q [CORE_ST];
  core_t              st_d [CORE_ST];
  logic [CORE_ST-1:0] vld_q;

  always_comb begin
    core_t c;
    res_t  ra, rb, rc, rd;

    // normalized coordinates
    c      = '0;
    c.zbad = data_i.zbad;
    ra     = from_mag(data_i.negx, data_i.wx);
    rb     = from_mag(data_i.negy, data_i.wy);
    c.xn   = ra.val;
    c.yn   = rb.val;
    c.sat  = ra.flag | rb.flag;
    st_d[0] = c;

    c = st_q[0];
    c.pp[0] = mul_pp(c.xn, c.xn);
    c.pp[1] = mul_pp(c.yn, c.yn);
    c.pp[2] = mul_pp(c.xn, c.yn);
    st_d[1] = c;

    c = st_q[1];
    ra = mul_fin(c.pp[0]);
    rb = mul_fin(c.pp[1]);
    rc = mul_fin(c.pp[2]);
    c.x2  = ra.val;
    c.y2  = rb.val;
    c.xy  = rc.val;
    c.ssq = ra.flag | rb.flag | rc.flag;
    st_d[2] = c;

    c = st_q[2];
    ra = add_sat(c.x2, c.y2);
    rb = add_sat(c.xy, c.xy);
    rc = add_sat(c.x2, c.x2);
    rd = add_sat(c.y2, c.y2);
    c.r2  = ra.val;
    c.txy = rb.val;
    c.x2d = rc.val;
    c.y2d = rd.val;
    c.ssq = c.ssq | ra.flag;
    c.st  = rb.flag | rc.flag | rd.flag;
    st_d[3] = c;

    c = st_q[3];
    ra = add_sat(c.r2, c.x2d);
    rb = add_sat(c.r2, c.y2d);
    c.tx = ra.val;
    c.ty = rb.val;
    c.st = c.st | ra.flag | rb.flag;
    c.pp[0] = mul_pp(c.r2, c.r2);
    c.pp[1] = mul_pp(k1, c.r2);
    c.pp[2] = mul_pp(p1, c.txy);
    c.pp[3] = mul_pp(p2, c.txy);
    st_d[4] = c;

    c = st_q[4];
    ra = mul_fin(c.pp[0]);
    rb = mul_fin(c.pp[1]);
    rc = mul_fin(c.pp[2]);
    rd = mul_fin(c.pp[3]);
    c.r4    = ra.val;
    c.s4    = c.ssq | ra.flag;
    c.k1r2  = rb.val;
    c.p1txy = rc.val;
    c.p2txy = rd.val;
    c.sat   = c.sat | rb.flag | rc.flag | rd.flag;
    c.pp[0] = mul_pp(p2, c.tx);
    c.pp[1] = mul_pp(p1, c.ty);
    st_d[5] = c;

    c = st_q[5];
    ra = mul_fin(c.pp[0]);
    rb = mul_fin(c.pp[1]);
    c.p2tx = ra.val;
    c.p1ty = rb.val;
    c.sat  = c.sat | ra.flag | rb.flag;
    c.pp[0] = mul_pp(c.r4, c.r2);
    c.pp[1] = mul_pp(k2, c.r4);
    st_d[6] = c;

    c = st_q[6];
    ra = mul_fin(c.pp[0]);
    rb = mul_fin(c.pp[1]);
    c.r6   = ra.val;
    c.s6   = c.s4 | ra.flag;
    c.k2r4 = rb.val;
    c.sat  = c.sat | rb.flag;
    st_d[7] = c;

    c = st_q[7];
    ra = add_sat(c.k1r2, c.k2r4);
    c.rad = ra.val;
    c.sat = c.sat | ra.flag;
    c.pp[0] = mul_pp(k3, c.r6);
    st_d[8] = c;

    c = st_q[8];
    ra = mul_fin(c.pp[0]);
    c.k3r6 = ra.val;
    c.sat  = c.sat | ra.flag;
    st_d[9] = c;

    c = st_q[9];
    ra = add_sat(c.rad, c.k3r6);
    c.rad = ra.val;
    c.sat = c.sat | ra.flag;
    st_d[10] = c;

    c = st_q[10];
    c.pp[0] = mul_pp(c.xn, c.rad);
    c.pp[1] = mul_pp(c.yn, c.rad);
    st_d[11] = c;

    c = st_q[11];
    ra = mul_fin(c.pp[0]);
    rb = mul_fin(c.pp[1]);
    c.xd  = ra.val;
    c.yd  = rb.val;
    c.sat = c.sat | ra.flag | rb.flag;
    st_d[12] = c;

    c = st_q[12];
    ra = add_sat(c.xn, c.xd);
    rb = add_sat(c.yn, c.yd);
    c.xd  = ra.val;
    c.yd  = rb.val;
    c.sat = c.sat | ra.flag | rb.flag;
    st_d[13] = c;

    c = st_q[13];
    ra = add_sat(c.xd, c.p1txy);
    rb = add_sat(c.yd, c.p2txy);
    c.xd  = ra.val;
    c.yd  = rb.val;
    c.sat = c.sat | ra.flag | rb.flag;
    st_d[14] = c;

    // intermediate overflow counts only where a coefficient uses it
    c = st_q[14];
    ra = add_sat(c.xd, c.p2tx);
    rb = add_sat(c.yd, c.p1ty);
    c.xd  = ra.val;
    c.yd  = rb.val;
    c.sat = c.sat | ra.flag | rb.flag | (use_k1 & c.ssq) | (use_k2 & c.s4)
          | (use_k3 & c.s6) | (use_p & (c.ssq | c.st));
    st_d[15] = c;

    c = st_q[15];
    c.pp[0] = mul_pp(fxq, c.xd);
    c.pp[1] = mul_pp(fyq, c.yd);
    st_d[16] = c;

    c = st_q[16];
    ra = mul_fin(c.pp[0]);
    rb = mul_fin(c.pp[1]);
    c.xd  = ra.val;
    c.yd  = rb.val;
    c.sat = c.sat | ra.flag | rb.flag;
    st_d[17] = c;

    c = st_q[17];
    ra = add_sat(c.xd, cxq);
    rb = add_sat(c.yd, cyq);
    c.xd  = ra.val;
    c.yd  = rb.val;
    c.sat = c.sat | ra.flag | rb.flag;
    st_d[18] = c;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < CORE_ST; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[CORE_ST-2:0], valid_i};
    end
  end

  assign valid_o     = vld_q[CORE_ST-1];
  assign data_o.zbad = st_q[CORE_ST-1].zbad;
  assign data_o.sat  = st_q[CORE_ST-1].sat;
  assign data_o.u    = st_q[CORE_ST-1].xd;
  assign data_o.v    = st_q[CORE_ST-1].yd;

endmodule

`default_nettype wire

### hdl/distorted_pinhole_projection.sv
// Distorted pinhole projection (Brown-Conrady radial and tangential terms).
// Input channel: point_x/y/z_i, signed Q16.16, under in_valid_i / in_stall_o.
// Output channel: pixel_u/v_o, signed Q16.16, and status_o (ok, depth not
// positive, saturated), under out_valid_o / out_stall_i.
// Config channel: cfg_index_i selects focal_x, focal_y, principal_point,
// k1, k2, p1, p2, k3; cfg_data_i is written when cfg_valid_i is high
// (cfg_ready_o is always high). Unknown indexes are dropped. Write only
// while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. From accept
// to out_valid_o an item passes the queue (written at the accept edge), then
// 64 divider steps, one quotient bit per stage, 19 distortion stages, 1 output register.
// A 2-entry queue sits in front of the divider. A stall on the output while
// out_valid_o is high freezes the whole divider and distortion pipeline;
// the queue keeps taking items until it is full.
// Reset clears the queue, all valid bits and the configuration
// (focal lengths 1.0, everything else 0).
`default_nettype none

module distorted_pinhole_projection import dpp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [31:0]          point_x_i,
  input  wire logic [31:0]          point_y_i,
  input  wire logic [31:0]          point_z_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [31:0]               pixel_u_o,
  output logic [31:0]               pixel_v_o,
  output logic [1:0]                status_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]          cfg_data_i
);

  typedef struct packed {
    logic        flag;
    logic [31:0] val;
  } pix_t;

  function automatic pix_t to_out(q64_t w);
    pix_t        p;
    logic [63:0] m, r;
    m = w[63] ? (~w + 64'd1) : w;
    r = (m + 64'h8000) >> 16;
    p.flag = 1'b0;
    if (w[63]) begin
      if (r > 64'h8000_0000) begin
        p.flag = 1'b1;
        r      = 64'h8000_0000;
      end
      p.val = 32'(64'd0 - r);
    end else begin
      if (r > 64'h7FFF_FFFF) begin
        p.flag = 1'b1;
        r      = 64'h7FFF_FFFF;
      end
      p.val = r[31:0];
    end
    return p;
  endfunction

  cfg_t      cfg_q;
  logic      adv;
  logic      q_valid, div_valid, core_valid;
  div_t      q_data, div_data;
  core_out_t core_data;
  pix_t      pu, pv;

  logic        out_valid_q;
  logic [31:0] pixel_u_q, pixel_v_q;
  logic [1:0]  status_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fx <= FOCAL_RESET;
      cfg_q.fy <= FOCAL_RESET;
      cfg_q.cx <= '0;
      cfg_q.cy <= '0;
      cfg_q.k1 <= '0;
      cfg_q.k2 <= '0;
      cfg_q.p1 <= '0;
      cfg_q.p2 <= '0;
      cfg_q.k3 <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FOCAL_X:   cfg_q.fx <= cfg_data_i[31:0];
        REG_FOCAL_Y:   cfg_q.fy <= cfg_data_i[31:0];
        REG_PRINCIPAL: begin
          cfg_q.cx <= cfg_data_i[63:32];
          cfg_q.cy <= cfg_data_i[31:0];
        end
        REG_K1:        cfg_q.k1 <= cfg_data_i[31:0];
        REG_K2:        cfg_q.k2 <= cfg_data_i[31:0];
        REG_P1:        cfg_q.p1 <= cfg_data_i[31:0];
        REG_P2:        cfg_q.p2 <= cfg_data_i[31:0];
        REG_K3:        cfg_q.k3 <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign adv = ~out_valid_q | ~out_stall_i;

  dpp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .pop_i      (adv),
    .valid_o    (q_valid),
    .data_o     (q_data)
  );

  dpp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (q_valid),
    .data_i  (q_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  dpp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg_q),
    .valid_i (div_valid),
    .data_i  (div_data),
    .valid_o (core_valid),
    .data_o  (core_data)
  );

  assign pu = to_out(core_data.u);
  assign pv = to_out(core_data.v);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (core_data.zbad) begin
        pixel_u_q <= 32'd0;
        pixel_v_q <= 32'd0;
        status_q  <= ST_DEPTH;
      end else begin
        pixel_u_q <= pu.val;
        pixel_v_q <= pv.val;
        status_q  <= (core_data.sat | pu.flag | pv.flag) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= core_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_u_o   = pixel_u_q;
  assign pixel_v_o   = pixel_v_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire
